>>> rtl/core/sfpe_pkg.sv
// shared types, constants and crc table for the sent frame pulse encoder
package sfpe_pkg;

	localparam int MAX_NIBBLES = 6;

	localparam int FRAME_W    = 24;
	localparam int NIB_W      = 4;
	localparam int COUNT_W    = 3;
	localparam int TICK_W     = 12;
	localparam int HTICK_W    = 7;
	localparam int LOW_CYC_W  = 16;
	localparam int HIGH_CYC_W = 19;
	localparam int IDX_W      = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [HTICK_W-1:0] SYNC_TICKS        = 7'd51;
	localparam logic [HTICK_W-1:0] PAUSE_TICKS       = 7'd72;
	localparam logic [HTICK_W-1:0] NIBBLE_BASE_TICKS = 7'd7;

	typedef enum logic [1:0] {
		KIND_SYNC  = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_CRC   = 2'd2,
		KIND_PAUSE = 2'd3
	} pulse_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NIBBLE_COUNT = 3'd0,
		REG_PAUSE_ENABLE = 3'd1,
		REG_CRC_SEED     = 3'd2,
		REG_LOW_TICKS    = 3'd3,
		REG_TICK_CLOCKS  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] nibble_count;
		logic               pause_enable;
		logic [NIB_W-1:0]   crc_seed;
		logic [NIB_W-1:0]   low_pulse_ticks;
		logic [TICK_W-1:0]  tick_clocks;
	} sfpe_cfg_t;

	localparam logic [NIB_W-1:0] CRC4_TABLE [16] = '{
		4'd0, 4'd13, 4'd7, 4'd10, 4'd14, 4'd3, 4'd9, 4'd4,
		4'd1, 4'd12, 4'd6, 4'd11, 4'd15, 4'd2, 4'd8, 4'd5
	};

	function automatic logic [NIB_W-1:0] crc4_lookup(input logic [NIB_W-1:0] c);
		return CRC4_TABLE[c];
	endfunction

endpackage

>>> rtl/core/sfpe_cfg_regs.sv
// configuration register file of the sent frame pulse encoder
module sfpe_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sfpe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfpe_pkg::CFG_DATA_W-1:0]   cfg_data,
	output sfpe_pkg::sfpe_cfg_t               cfg
);

	sfpe_pkg::sfpe_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nibble_count    <= 3'd6;
			cfg_q.pause_enable    <= 1'b0;
			cfg_q.crc_seed        <= 4'd5;
			cfg_q.low_pulse_ticks <= 4'd5;
			cfg_q.tick_clocks     <= 12'd3;
		end else if (cfg_valid) begin
			unique case (sfpe_pkg::cfg_reg_t'(cfg_index))
				sfpe_pkg::REG_NIBBLE_COUNT: cfg_q.nibble_count <= cfg_data[2:0];
				sfpe_pkg::REG_PAUSE_ENABLE: cfg_q.pause_enable <= cfg_data[0];
				sfpe_pkg::REG_CRC_SEED:     cfg_q.crc_seed <= cfg_data[3:0];
				sfpe_pkg::REG_LOW_TICKS:    cfg_q.low_pulse_ticks <= cfg_data[3:0];
				sfpe_pkg::REG_TICK_CLOCKS:  cfg_q.tick_clocks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

>>> rtl/core/sent_frame_pulse_encoder.sv
// top level of the sent frame pulse encoder: frame register, pulse sequencer, output register
//
//  channel | signals                                             | direction
//  in      | in_valid, in_ready, frame_nibbles                   | frame beat in
//  out     | out_valid, out_ready, pulse_kind, nibble_value,     | pulse beat out
//          | low_cycles, high_cycles, last_pulse                 |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data           | register write
//
// one pulse beat per cycle from the frame register while out_ready allows: a frame
// gives n + 2 beats (n + 3 with the pause), so 3 to 9 beats, set by the pulse counter.
// the next frame is taken in the cycle the last pulse of the current one is built.
// both multiplies of a beat sit between the frame register and the output register.
// reset empties both registers and loads register defaults; out_ready low holds
// the output beat and stalls the sequencer, cfg_ready is always high.
module sent_frame_pulse_encoder #(
	parameter int MAX_NIBBLES = sfpe_pkg::MAX_NIBBLES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [sfpe_pkg::FRAME_W-1:0]       frame_nibbles,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         pulse_kind,
	output logic [sfpe_pkg::NIB_W-1:0]         nibble_value,
	output logic [sfpe_pkg::LOW_CYC_W-1:0]     low_cycles,
	output logic [sfpe_pkg::HIGH_CYC_W-1:0]    high_cycles,
	output logic                               last_pulse,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sfpe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sfpe_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam logic [sfpe_pkg::COUNT_W-1:0] MAX_N = sfpe_pkg::COUNT_W'(MAX_NIBBLES);

	sfpe_pkg::sfpe_cfg_t cfg;

	logic                               busy_q;
	logic [sfpe_pkg::FRAME_W-1:0]       frame_q;
	logic [sfpe_pkg::IDX_W-1:0]         idx_q;
	logic [sfpe_pkg::NIB_W-1:0]         crc_q;

	logic                               out_valid_q;
	sfpe_pkg::pulse_kind_t              kind_q;
	logic [sfpe_pkg::NIB_W-1:0]         nib_q;
	logic [sfpe_pkg::LOW_CYC_W-1:0]     low_q;
	logic [sfpe_pkg::HIGH_CYC_W-1:0]    high_q;
	logic                               last_q;

	logic                               out_free;
	logic                               gen_fire;
	logic [sfpe_pkg::COUNT_W-1:0]       n_eff;
	logic [sfpe_pkg::IDX_W-1:0]         crc_idx;
	sfpe_pkg::pulse_kind_t              kind;
	logic [sfpe_pkg::NIB_W-1:0]         nib;
	logic [sfpe_pkg::NIB_W-1:0]         data_nib;
	logic [sfpe_pkg::NIB_W-1:0]         crc_final;
	logic [sfpe_pkg::HTICK_W-1:0]       high_ticks;
	logic                               last;

	sfpe_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign out_free = !out_valid_q || out_ready;
	assign gen_fire = busy_q && out_free;
	assign in_ready = !busy_q || (gen_fire && last);

	// clamp nibble count into 1..MAX_NIBBLES
	always_comb begin
		if (cfg.nibble_count == '0) begin
			n_eff = sfpe_pkg::COUNT_W'(1);
		end else if (cfg.nibble_count > MAX_N) begin
			n_eff = MAX_N;
		end else begin
			n_eff = cfg.nibble_count;
		end
	end

	assign crc_idx   = sfpe_pkg::IDX_W'(n_eff) + sfpe_pkg::IDX_W'(1);
	assign data_nib  = frame_q[sfpe_pkg::FRAME_W-1 -: sfpe_pkg::NIB_W];
	assign crc_final = sfpe_pkg::crc4_lookup(crc_q);

	// pulse index: 0 sync, 1..n data, n+1 crc, n+2 pause
	always_comb begin
		if (idx_q == '0) begin
			kind = sfpe_pkg::KIND_SYNC;
		end else if (idx_q < crc_idx) begin
			kind = sfpe_pkg::KIND_DATA;
		end else if (idx_q == crc_idx) begin
			kind = sfpe_pkg::KIND_CRC;
		end else begin
			kind = sfpe_pkg::KIND_PAUSE;
		end
	end

	always_comb begin
		case (kind)
			sfpe_pkg::KIND_SYNC: begin
				nib        = '0;
				high_ticks = sfpe_pkg::SYNC_TICKS;
				last       = 1'b0;
			end
			sfpe_pkg::KIND_DATA: begin
				nib        = data_nib;
				high_ticks = sfpe_pkg::NIBBLE_BASE_TICKS + sfpe_pkg::HTICK_W'(data_nib);
				last       = 1'b0;
			end
			sfpe_pkg::KIND_CRC: begin
				nib        = crc_final;
				high_ticks = sfpe_pkg::NIBBLE_BASE_TICKS + sfpe_pkg::HTICK_W'(crc_final);
				last       = !cfg.pause_enable;
			end
			default: begin
				nib        = '0;
				high_ticks = sfpe_pkg::PAUSE_TICKS;
				last       = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (gen_fire) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + sfpe_pkg::IDX_W'(1);
			end
		end
	end

	// frame shifts left one nibble per data beat; crc runs alongside
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			frame_q <= frame_nibbles;
		end else if (gen_fire && kind == sfpe_pkg::KIND_DATA) begin
			frame_q <= {frame_q[sfpe_pkg::FRAME_W-sfpe_pkg::NIB_W-1:0],
				{sfpe_pkg::NIB_W{1'b0}}};
		end
		if (gen_fire) begin
			if (kind == sfpe_pkg::KIND_SYNC) begin
				crc_q <= cfg.crc_seed;
			end else if (kind == sfpe_pkg::KIND_DATA) begin
				crc_q <= sfpe_pkg::crc4_lookup(crc_q) ^ data_nib;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (gen_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (gen_fire) begin
			kind_q <= kind;
			nib_q  <= nib;
			low_q  <= sfpe_pkg::LOW_CYC_W'(cfg.low_pulse_ticks)
				* sfpe_pkg::LOW_CYC_W'(cfg.tick_clocks);
			high_q <= sfpe_pkg::HIGH_CYC_W'(high_ticks)
				* sfpe_pkg::HIGH_CYC_W'(cfg.tick_clocks);
			last_q <= last;
		end
	end

	assign out_valid    = out_valid_q;
	assign pulse_kind   = kind_q;
	assign nibble_value = nib_q;
	assign low_cycles   = low_q;
	assign high_cycles  = high_q;
	assign last_pulse   = last_q;

endmodule

>>> dv/tb.sv
// testbench for the sent frame pulse encoder: pulse predictor, random frames and registers
`timescale 1ns / 100ps

module tb;

	localparam int SYNC_LEN  = 51;
	localparam int PAUSE_LEN = 72;
	localparam int NIB_BASE  = 7;
	localparam int MAX_NIB   = 6;

	localparam logic [sfpe_pkg::NIB_W-1:0] CRC_LUT [16] = '{
		4'd0, 4'd13, 4'd7, 4'd10, 4'd14, 4'd3, 4'd9, 4'd4,
		4'd1, 4'd12, 4'd6, 4'd11, 4'd15, 4'd2, 4'd8, 4'd5
	};

	typedef struct {
		sfpe_pkg::pulse_kind_t               kind;
		logic [sfpe_pkg::NIB_W-1:0]          nib;
		logic [sfpe_pkg::LOW_CYC_W-1:0]      low_cyc;
		logic [sfpe_pkg::HIGH_CYC_W-1:0]     high_cyc;
		logic                                last;
	} pulse_t;

	class pulse_scoreboard;
		sfpe_pkg::sfpe_cfg_t cfg;
		pulse_t    pulse_q[$];
		int        errors;
		int        frames;
		int        pulses;
		int        reg_writes;

		function new();
			cfg = '{nibble_count: 3'd6, pause_enable: 1'b0, crc_seed: 4'd5,
				low_pulse_ticks: 4'd5, tick_clocks: 12'd3};
		endfunction

		function void set_reg(logic [sfpe_pkg::CFG_IDX_W-1:0] idx,
				logic [sfpe_pkg::CFG_DATA_W-1:0] word);
			reg_writes++;
			case (idx)
			sfpe_pkg::REG_NIBBLE_COUNT: cfg.nibble_count    = word[sfpe_pkg::COUNT_W-1:0];
			sfpe_pkg::REG_PAUSE_ENABLE: cfg.pause_enable    = word[0];
			sfpe_pkg::REG_CRC_SEED:     cfg.crc_seed        = word[sfpe_pkg::NIB_W-1:0];
			sfpe_pkg::REG_LOW_TICKS:    cfg.low_pulse_ticks = word[sfpe_pkg::NIB_W-1:0];
			sfpe_pkg::REG_TICK_CLOCKS:  cfg.tick_clocks     = word[sfpe_pkg::TICK_W-1:0];
			default: ;
			endcase
		endfunction

		function void add_pulse(sfpe_pkg::pulse_kind_t kind, logic [sfpe_pkg::NIB_W-1:0] nib,
				int high_ticks, logic last);
			pulse_t p;
			p.kind     = kind;
			p.nib      = nib;
			p.low_cyc  = sfpe_pkg::LOW_CYC_W'(int'(cfg.low_pulse_ticks)
				* int'(cfg.tick_clocks));
			p.high_cyc = sfpe_pkg::HIGH_CYC_W'(high_ticks * int'(cfg.tick_clocks));
			p.last     = last;
			pulse_q.push_back(p);
		endfunction

		// expected pulse train of one accepted frame beat
		function void note_frame(logic [sfpe_pkg::FRAME_W-1:0] frame);
			int                         n;
			logic [sfpe_pkg::NIB_W-1:0] crc;
			logic [sfpe_pkg::NIB_W-1:0] nib;
			frames++;
			n = cfg.nibble_count;
			if (n < 1)
				n = 1;
			if (n > MAX_NIB)
				n = MAX_NIB;
			crc = cfg.crc_seed;
			add_pulse(sfpe_pkg::KIND_SYNC, '0, SYNC_LEN, 1'b0);
			for (int i = 0; i < n; i++) begin
				nib = frame[sfpe_pkg::FRAME_W-1-4*i -: sfpe_pkg::NIB_W];
				add_pulse(sfpe_pkg::KIND_DATA, nib, NIB_BASE + nib, 1'b0);
				crc = CRC_LUT[crc] ^ nib;
			end
			// closing step for the implicit zero nibble
			crc = CRC_LUT[crc];
			add_pulse(sfpe_pkg::KIND_CRC, crc, NIB_BASE + crc, !cfg.pause_enable);
			if (cfg.pause_enable)
				add_pulse(sfpe_pkg::KIND_PAUSE, '0, PAUSE_LEN, 1'b1);
		endfunction

		function void compare(string what, logic [31:0] exp_v, logic [31:0] act_v);
			if (exp_v !== act_v) begin
				errors++;
				$display("%0t: pulse %0d %s mismatch, expected %0d, actual %0d",
					$time, pulses, what, exp_v, act_v);
			end
		endfunction

		function void check_pulse(logic [1:0] kind, logic [sfpe_pkg::NIB_W-1:0] nib,
				logic [sfpe_pkg::LOW_CYC_W-1:0] low_cyc,
				logic [sfpe_pkg::HIGH_CYC_W-1:0] high_cyc, logic last);
			pulse_t e;
			if (pulse_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected pulse beat, expected none, actual kind %0d nibble %0d",
					$time, kind, nib);
				return;
			end
			e = pulse_q.pop_front();
			compare("pulse_kind", e.kind, kind);
			compare("nibble_value", e.nib, nib);
			compare("low_cycles", e.low_cyc, low_cyc);
			compare("high_cycles", e.high_cyc, high_cyc);
			compare("last_pulse", e.last, last);
			pulses++;
		endfunction

		function int pending();
			return pulse_q.size();
		endfunction
	endclass

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 in_valid = 1'b0;
	logic                                 in_ready;
	logic [sfpe_pkg::FRAME_W-1:0]         frame_nibbles = '0;
	logic                                 out_valid;
	logic                                 out_ready = 1'b0;
	logic [1:0]                           pulse_kind;
	logic [sfpe_pkg::NIB_W-1:0]           nibble_value;
	logic [sfpe_pkg::LOW_CYC_W-1:0]       low_cycles;
	logic [sfpe_pkg::HIGH_CYC_W-1:0]      high_cycles;
	logic                                 last_pulse;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	logic [sfpe_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
	logic [sfpe_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

	int                                   src_idle = 0;
	int                                   sink_stall = 0;
	int                                   settings = 1;
	logic [sfpe_pkg::FRAME_W-1:0]         frame_plan[$];
	pulse_scoreboard                      sb = new();

	sent_frame_pulse_encoder dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= sink_stall);

	// outputs are stable at the falling edge, the beat moves at the next rising edge
	always @(negedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_pulse(pulse_kind, nibble_value, low_cycles, high_cycles, last_pulse);

	task automatic set_mode(int mode);
		case (mode)
		1:       begin src_idle = 48; sink_stall = 0;  end
		2:       begin src_idle = 0;  sink_stall = 48; end
		3:       begin src_idle = 34; sink_stall = 34; end
		default: begin src_idle = 0;  sink_stall = 0;  end
		endcase
	endtask

	task automatic drain();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// leaves cfg_valid high, the caller lowers it after the last beat
	task automatic write_reg(logic [sfpe_pkg::CFG_IDX_W-1:0] idx, int value, int w);
		logic [sfpe_pkg::CFG_DATA_W-1:0] word;
		// bits above the register width carry junk
		word = (sfpe_pkg::CFG_DATA_W'($urandom) << w) | sfpe_pkg::CFG_DATA_W'(value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= word;
		do @(negedge clk); while (!cfg_ready);
		sb.set_reg(idx, word);
		@(posedge clk);
	endtask

	task automatic configure(int nc, int pe, int seed, int lt, int tc);
		write_reg(sfpe_pkg::REG_NIBBLE_COUNT, nc, sfpe_pkg::COUNT_W);
		write_reg(sfpe_pkg::REG_PAUSE_ENABLE, pe, 1);
		write_reg(sfpe_pkg::REG_CRC_SEED, seed, sfpe_pkg::NIB_W);
		write_reg(sfpe_pkg::REG_LOW_TICKS, lt, sfpe_pkg::NIB_W);
		write_reg(sfpe_pkg::REG_TICK_CLOCKS, tc, sfpe_pkg::TICK_W);
		// writes past the register list must change nothing
		if ($urandom_range(1))
			write_reg(sfpe_pkg::CFG_IDX_W'($urandom_range(7, 5)), $urandom, 0);
		cfg_valid <= 1'b0;
		settings++;
		@(posedge clk);
	endtask

	task automatic random_config();
		int lt;
		int tc;
		lt = ($urandom_range(4) == 0) ? $urandom_range(3) : $urandom_range(15, 4);
		case ($urandom_range(7))
		0, 1:    tc = 4095;
		2, 3:    tc = $urandom_range(8, 1);
		4:       tc = 0;
		default: tc = $urandom_range(4095);
		endcase
		configure($urandom_range(7), $urandom_range(1), $urandom_range(15), lt, tc);
	endtask

	task automatic send_frame(logic [sfpe_pkg::FRAME_W-1:0] f);
		int gap;
		gap = 0;
		while ($urandom_range(99) < src_idle)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		frame_nibbles <= f;
		do @(negedge clk); while (!in_ready);
		sb.note_frame(f);
		@(posedge clk);
	endtask

	task automatic run_frames(int mode);
		set_mode(mode);
		foreach (frame_plan[k]) begin
			// sender holds off until the pulse train is fully out
			if (frame_plan.size() >= 8 && k == frame_plan.size() / 2) begin
				in_valid <= 1'b0;
				drain();
			end
			send_frame(frame_plan[k]);
		end
		in_valid <= 1'b0;
		drain();
	endtask

	function automatic logic [sfpe_pkg::FRAME_W-1:0] pick_frame();
		logic [sfpe_pkg::FRAME_W-1:0] f;
		f = sfpe_pkg::FRAME_W'($urandom);
		if ($urandom_range(3) == 0)
			for (int i = 0; i < MAX_NIB; i++)
				f[4*i +: sfpe_pkg::NIB_W] = $urandom_range(1) ? 4'hF : 4'h0;
		return f;
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults after reset
		frame_plan = {24'h000000, 24'hFFFFFF, 24'h123456, 24'hFEDCBA, 24'hA5A5A5,
			24'h5A5A5A, 24'h800001};
		run_frames(0);
		// zero nibble count, zero low ticks and zero tick length
		configure(0, 1, 0, 0, 0);
		frame_plan = {24'hFFFFFF, 24'h0F0000, 24'h000000};
		run_frames(0);
		// nibble count above the maximum, longest durations
		configure(7, 1, 15, 15, 4095);
		frame_plan = {24'hFFFFFF, 24'h000000, 24'h3C5A96};
		run_frames(0);
		configure(1, 0, 15, 4, 1);
		frame_plan = {24'hF00000, 24'h0FFFFF};
		run_frames(0);
		configure(3, 1, 9, 3, 2);
		frame_plan = {24'hABC000, 24'h7E1D42};
		run_frames(0);

		for (int ph = 0; ph < 8; ph++) begin
			random_config();
			frame_plan = {};
			repeat (16) frame_plan.push_back(pick_frame());
			run_frames(ph % 4);
		end

		drain();
		repeat (20) @(posedge clk);
		$display("run covered %0d frames, %0d pulse beats checked, %0d register settings",
			sb.frames, sb.pulses, settings);
		$display("idling phases: none, sender gaps, receiver stalls and both; %0d mismatches",
			sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#400000;
		$display("timeout with %0d pulse beats outstanding", sb.pending());
		$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sent_frame_pulse_encoder.f
rtl/core/sfpe_pkg.sv
rtl/core/sfpe_cfg_regs.sv
rtl/core/sent_frame_pulse_encoder.sv
dv/tb.sv
